/* rtl/core/prd_pkg.sv */
`timescale 1ns / 1ps

package prd_pkg;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_FORWARD = 3'd0,
		REG_RIGHT   = 3'd1,
		REG_UP      = 3'd2,
		REG_HFOV    = 3'd3,
		REG_VFOV    = 3'd4
	} reg_idx_t;

	// Arctangent polynomial constants, Q2.14.
	localparam logic signed [15:0] QPI_Q14 = 16'sd12868;
	localparam logic [27:0]        CA_Q14  = 28'd4009;
	localparam logic [27:0]        CB_Q14  = 28'd1086;
	localparam logic signed [18:0] ONE_Q14 = 19'sd16384;
	localparam logic signed [16:0] CLAMP_Q14 = 17'sd16384;

	// Reset values of the camera registers.
	localparam logic [47:0] FORWARD_RST = 48'h0000_0000_4000;
	localparam logic [47:0] RIGHT_RST   = 48'h4000_0000_0000;
	localparam logic [47:0] UP_RST      = 48'h0000_4000_0000;
	localparam logic [15:0] FOV_RST     = 16'd17157;

endpackage

/* rtl/core/perspective_ray_direction_unit.sv */
`timescale 1ns / 1ps

// Pinhole camera ray direction unit.
// A transaction is accepted on every rising edge at which start is high and busy is
// low. busy is never raised: the pipeline takes one sample per clock, without gaps.
// Each sample carries screen_u and screen_v (Q0.16) and the jitter offsets (Q2.14).
// The result dir_x, dir_y, dir_z (unit vector, Q2.14) is valid for exactly one cycle
// while done is high; the receiver cannot stall, and as the pipeline never stops
// nothing waits for it. The pipeline consists of the arctangent and projection front
// end (9 stages), the square root (15 stages of two result bits each), a preparation
// stage, the three parallel dividers (8 stages of two quotient bits each) and the
// output register.
// The camera vectors and fields of view must be written on the cfg_we/cfg_index/cfg_wdata
// port while no transaction is in flight, which the unit does not enforce; indexes above
// the last register are ignored. Reset clears every in-flight transaction and restores
// the default camera: looking along x, with z to the right and y up.
module perspective_ray_direction_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [47:0]        cfg_wdata,
	input  logic               start,
	output logic               busy,
	input  logic [15:0]        screen_u,
	input  logic [15:0]        screen_v,
	input  logic signed [15:0] jitter_u,
	input  logic signed [15:0] jitter_v,
	output logic               done,
	output logic signed [15:0] dir_x,
	output logic signed [15:0] dir_y,
	output logic signed [15:0] dir_z
);

	localparam int SQ_STAGES  = 15;
	localparam int DIV_STAGES = 8;
	localparam int FRONT      = 9;
	localparam int PREP       = FRONT + SQ_STAGES + 1;
	localparam int LAT        = PREP + DIV_STAGES + 1;

	logic [47:0] forward_q, right_q, up_q;
	logic [15:0] hfov_q, vfov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forward_q <= prd_pkg::FORWARD_RST;
			right_q   <= prd_pkg::RIGHT_RST;
			up_q      <= prd_pkg::UP_RST;
			hfov_q    <= prd_pkg::FOV_RST;
			vfov_q    <= prd_pkg::FOV_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				prd_pkg::REG_FORWARD: forward_q <= cfg_wdata;
				prd_pkg::REG_RIGHT:   right_q   <= cfg_wdata;
				prd_pkg::REG_UP:      up_q      <= cfg_wdata;
				prd_pkg::REG_HFOV:    hfov_q    <= cfg_wdata[15:0];
				prd_pkg::REG_VFOV:    vfov_q    <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	logic [LAT:1] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LAT-1:1], accept};
		end
	end

	// Channel 0 is horizontal, channel 1 vertical.
	logic signed [16:0] off_c [2];
	logic signed [33:0] prod_s1 [2];
	logic signed [15:0] jit_s1 [2], jit_s2 [2], jit_s3 [2], jit_s4 [2];

	always_comb begin
		off_c[0] = $signed({1'b0, screen_u}) - 17'sd32768;
		off_c[1] = 17'sd32768 - $signed({1'b0, screen_v});
	end

	always_ff @(posedge clk) begin
		prod_s1[0] <= $signed({1'b0, hfov_q}) * off_c[0];
		prod_s1[1] <= $signed({1'b0, vfov_q}) * off_c[1];
		jit_s1[0]  <= jitter_u;
		jit_s1[1]  <= jitter_v;
	end

	// Stage 2: scaled offset rounded to Q2.14.
	logic [33:0]        pmag_c [2];
	logic [33:0]        prnd_c [2];
	logic signed [17:0] x_c [2];
	logic signed [17:0] x_s2 [2];

	always_comb begin
		for (int ch = 0; ch < 2; ch++) begin
			pmag_c[ch] = prod_s1[ch][33] ? 34'(-prod_s1[ch]) : 34'(prod_s1[ch]);
			prnd_c[ch] = (pmag_c[ch] + 34'd32768) >> 16;
			x_c[ch]    = prod_s1[ch][33] ? -$signed(prnd_c[ch][17:0])
			                             : $signed(prnd_c[ch][17:0]);
		end
	end

	always_ff @(posedge clk) begin
		x_s2   <= x_c;
		jit_s2 <= jit_s1;
	end

	// Stage 3: the linear term and the two factors of the correction term.
	logic [17:0]        a_c [2];
	logic signed [33:0] lin_c [2];
	logic signed [36:0] m_c [2];
	logic signed [33:0] lin_s3 [2];
	logic signed [30:0] m_s3 [2];
	logic [27:0]        p_s3 [2];

	always_comb begin
		for (int ch = 0; ch < 2; ch++) begin
			a_c[ch]   = x_s2[ch][17] ? 18'(-x_s2[ch]) : 18'(x_s2[ch]);
			lin_c[ch] = prd_pkg::QPI_Q14 * x_s2[ch];
			m_c[ch]   = x_s2[ch] * ($signed({1'b0, a_c[ch]}) - prd_pkg::ONE_Q14);
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 2; ch++) begin
			lin_s3[ch] <= lin_c[ch];
			m_s3[ch]   <= m_c[ch][30:0];
			p_s3[ch]   <= (prd_pkg::CA_Q14 << 14) + prd_pkg::CB_Q14 * 28'(a_c[ch]);
		end
		jit_s3 <= jit_s2;
	end

	// Stage 4: the Q56 arctangent value.
	logic signed [59:0] mp_c [2];
	logic signed [61:0] res_s4 [2];

	always_comb begin
		for (int ch = 0; ch < 2; ch++) begin
			mp_c[ch] = m_s3[ch] * $signed({1'b0, p_s3[ch]});
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 2; ch++) begin
			res_s4[ch] <= $signed({lin_s3[ch], 28'd0}) - 62'(mp_c[ch]);
		end
		jit_s4 <= jit_s3;
	end

	// Stage 5: round to Q2.14 and add the jitter.
	logic [61:0]        rmag_c [2];
	logic [61:0]        rrnd_c [2];
	logic signed [18:0] at_c [2];
	logic signed [18:0] rf_s5 [2];

	always_comb begin
		for (int ch = 0; ch < 2; ch++) begin
			rmag_c[ch] = res_s4[ch][61] ? 62'(-res_s4[ch]) : 62'(res_s4[ch]);
			rrnd_c[ch] = (rmag_c[ch] + (62'd1 << 41)) >> 42;
			at_c[ch]   = res_s4[ch][61] ? -$signed({1'b0, rrnd_c[ch][17:0]})
			                            : $signed({1'b0, rrnd_c[ch][17:0]});
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 2; ch++) begin
			rf_s5[ch] <= at_c[ch] + 19'(jit_s4[ch]);
		end
	end

	// Stage 6: per-component products of the camera axes.
	logic signed [29:0] pf_s6 [3];
	logic signed [34:0] pr_s6 [3], pu_s6 [3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			pf_s6[k] <= $signed({forward_q[16*k +: 16], 14'd0});
			pr_s6[k] <= $signed(right_q[16*k +: 16]) * rf_s5[0];
			pu_s6[k] <= $signed(up_q[16*k +: 16]) * rf_s5[1];
		end
	end

	// Stage 7: direction components rounded from Q28 to Q24.
	logic signed [36:0] q28_c [3];
	logic [36:0]        qmag_c [3];
	logic [36:0]        qrnd_c [3];
	logic signed [29:0] d_s7 [3], d_s8 [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			q28_c[k]  = 37'(pf_s6[k]) + 37'(pr_s6[k]) + 37'(pu_s6[k]);
			qmag_c[k] = q28_c[k][36] ? 37'(-q28_c[k]) : 37'(q28_c[k]);
			qrnd_c[k] = (qmag_c[k] + 37'd8) >> 4;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			d_s7[k] <= q28_c[k][36] ? -$signed({1'b0, qrnd_c[k][28:0]})
			                        : $signed({1'b0, qrnd_c[k][28:0]});
		end
	end

	// Stage 8: squares; stage 9: their sum.
	logic signed [59:0] sqp_c [3];
	logic [57:0]        sq_s8 [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sqp_c[k] = d_s7[k] * d_s7[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			sq_s8[k] <= sqp_c[k][57:0];
		end
		d_s8 <= d_s7;
	end

	// Square root, two result bits per stage. Index 0 is the stage 9 register.
	logic [59:0]        sq_n_s    [SQ_STAGES+1];
	logic [31:0]        sq_rem_s  [SQ_STAGES+1];
	logic [29:0]        sq_root_s [SQ_STAGES+1];
	logic signed [29:0] sq_d_s    [SQ_STAGES+1][3];

	logic [59:0] sq_n_c    [SQ_STAGES];
	logic [31:0] sq_rem_c  [SQ_STAGES];
	logic [29:0] sq_root_c [SQ_STAGES];

	always_comb begin
		logic [59:0] n;
		logic [31:0] rem;
		logic [29:0] root;
		logic [31:0] trial;
		for (int j = 0; j < SQ_STAGES; j++) begin
			n    = sq_n_s[j];
			rem  = sq_rem_s[j];
			root = sq_root_s[j];
			for (int t = 0; t < 2; t++) begin
				rem   = {rem[29:0], n[59:58]};
				n     = n << 2;
				trial = {root, 2'b01};
				if (rem >= trial) begin
					rem  = rem - trial;
					root = {root[28:0], 1'b1};
				end else begin
					root = {root[28:0], 1'b0};
				end
			end
			sq_n_c[j]    = n;
			sq_rem_c[j]  = rem;
			sq_root_c[j] = root;
		end
	end

	always_ff @(posedge clk) begin
		sq_n_s[0]    <= 60'(sq_s8[0]) + 60'(sq_s8[1]) + 60'(sq_s8[2]);
		sq_rem_s[0]  <= '0;
		sq_root_s[0] <= '0;
		sq_d_s[0]    <= d_s8;
		for (int j = 0; j < SQ_STAGES; j++) begin
			sq_n_s[j+1]    <= sq_n_c[j];
			sq_rem_s[j+1]  <= sq_rem_c[j];
			sq_root_s[j+1] <= sq_root_c[j];
			sq_d_s[j+1]    <= sq_d_s[j];
		end
	end

	// Division of each component by the norm, two quotient bits per stage.
	// Index 0 is the preparation register, which adds half the norm for rounding.
	logic [45:0] dv_rem_s  [DIV_STAGES+1][3];
	logic [15:0] dv_q_s    [DIV_STAGES+1][3];
	logic        dv_neg_s  [DIV_STAGES+1][3];
	logic [29:0] dv_norm_s [DIV_STAGES+1];
	logic        dv_zero_s [DIV_STAGES+1];

	logic [29:0] dmag_c [3];
	logic [45:0] dv_rem_c [DIV_STAGES][3];
	logic [15:0] dv_q_c   [DIV_STAGES][3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dmag_c[k] = sq_d_s[SQ_STAGES][k][29] ? 30'(-sq_d_s[SQ_STAGES][k])
			                                     : 30'(sq_d_s[SQ_STAGES][k]);
		end
	end

	always_comb begin
		logic [45:0] rem;
		logic [15:0] q;
		logic [45:0] den;
		for (int t = 0; t < DIV_STAGES; t++) begin
			for (int k = 0; k < 3; k++) begin
				rem = dv_rem_s[t][k];
				q   = dv_q_s[t][k];
				for (int u = 0; u < 2; u++) begin
					den = 46'(dv_norm_s[t]) << (15 - 2*t - u);
					if (rem >= den) begin
						rem = rem - den;
						q[15 - 2*t - u] = 1'b1;
					end
				end
				dv_rem_c[t][k] = rem;
				dv_q_c[t][k]   = q;
			end
		end
	end

	always_ff @(posedge clk) begin
		dv_norm_s[0] <= sq_root_s[SQ_STAGES];
		dv_zero_s[0] <= (sq_root_s[SQ_STAGES] == '0);
		for (int k = 0; k < 3; k++) begin
			dv_rem_s[0][k] <= (46'(dmag_c[k]) << 14) + 46'(sq_root_s[SQ_STAGES] >> 1);
			dv_q_s[0][k]   <= '0;
			dv_neg_s[0][k] <= sq_d_s[SQ_STAGES][k][29];
		end
		for (int t = 0; t < DIV_STAGES; t++) begin
			dv_norm_s[t+1] <= dv_norm_s[t];
			dv_zero_s[t+1] <= dv_zero_s[t];
			dv_rem_s[t+1]  <= dv_rem_c[t];
			dv_q_s[t+1]    <= dv_q_c[t];
			dv_neg_s[t+1]  <= dv_neg_s[t];
		end
	end

	// Output stage: sign, clamp and the zero-length case.
	logic signed [16:0] r_c [3];
	logic signed [15:0] o_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			r_c[k] = dv_neg_s[DIV_STAGES][k] ? -$signed({1'b0, dv_q_s[DIV_STAGES][k]})
			                                 : $signed({1'b0, dv_q_s[DIV_STAGES][k]});
			if (r_c[k] > prd_pkg::CLAMP_Q14) begin
				r_c[k] = prd_pkg::CLAMP_Q14;
			end
			if (r_c[k] < -prd_pkg::CLAMP_Q14) begin
				r_c[k] = -prd_pkg::CLAMP_Q14;
			end
			o_c[k] = dv_zero_s[DIV_STAGES] ? 16'sd0 : r_c[k][15:0];
		end
	end

	always_ff @(posedge clk) begin
		dir_x <= o_c[0];
		dir_y <= o_c[1];
		dir_z <= o_c[2];
	end

	assign done = vld_s[LAT];

	// A result only ever leaves for a transaction accepted the latency earlier.
	a_done_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without a matching transaction");

	// Every component is no longer than the norm, so the quotient fits its 15 bits.
	a_quotient_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[PREP] && !dv_zero_s[0]) |->
		(dv_rem_s[0][0] < (46'(dv_norm_s[0]) << 15)) &&
		(dv_rem_s[0][1] < (46'(dv_norm_s[0]) << 15)) &&
		(dv_rem_s[0][2] < (46'(dv_norm_s[0]) << 15)))
		else $error("division numerator exceeds quotient range");

	// A delivered direction stays within the unit range.
	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (dir_x <= 16'sd16384) && (dir_x >= -16'sd16384) &&
		         (dir_y <= 16'sd16384) && (dir_y >= -16'sd16384) &&
		         (dir_z <= 16'sd16384) && (dir_z >= -16'sd16384))
		else $error("direction component out of range");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam logic [2:0] IDX_SPARE_LO = 3'd5;
	localparam logic [2:0] IDX_SPARE_HI = 3'd7;
	localparam int         PIPE_DEPTH   = 34;
	localparam int         STALL_LIMIT  = 4000;
	localparam logic [15:0] FOV_MAX     = 16'd51472;

	typedef struct {
		logic [15:0]        u;
		logic [15:0]        v;
		logic signed [15:0] ju;
		logic signed [15:0] jv;
	} sample_t;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} dir_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [47:0]        cfg_wdata = '0;
	logic               start = 1'b0;
	logic               busy;
	logic [15:0]        screen_u = '0;
	logic [15:0]        screen_v = '0;
	logic signed [15:0] jitter_u = '0;
	logic signed [15:0] jitter_v = '0;
	logic               done;
	logic signed [15:0] dir_x, dir_y, dir_z;

	// Camera state as the unit should hold it.
	logic [47:0] cam_fwd, cam_right, cam_up;
	logic [15:0] cam_hfov, cam_vfov;

	sample_t pending_samples[$];
	dir_t    expected_dirs[$];
	sample_t cur_sample;
	int      gap_left = 0;
	int      burst_left = 0;
	int      mismatches = 0;
	int      quiet_cycles = 0;

	perspective_ray_direction_unit uut (.*);

	always #5 clk = ~clk;

	function automatic longint comp16(logic [47:0] vec, int k);
		logic [15:0] c;
		c = vec[16*k +: 16];
		return longint'($signed(c));
	endfunction

	function automatic longint round_shift(longint a, int s);
		longint unsigned ua;
		ua = (a < 0) ? longint'(-a) : a;
		ua = (ua + (64'd1 << (s - 1))) >> s;
		return (a < 0) ? -longint'(ua) : longint'(ua);
	endfunction

	function automatic longint round_div(longint n, longint d);
		longint unsigned un, r;
		un = (n < 0) ? longint'(-n) : n;
		r = (un + longint'(d) / 2) / longint'(d);
		return (n < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Polynomial arctangent, Q14 in and out, evaluated exactly in Q56.
	function automatic longint atan_poly(longint x);
		longint a, lin, m, p;
		a = (x < 0) ? -x : x;
		lin = 64'sd12868 * x;
		m = x * (a - 64'sd16384);
		p = (64'sd4009 <<< 14) + 64'sd1086 * a;
		return round_shift(lin * (64'sd1 <<< 28) - m * p, 42);
	endfunction

	function automatic dir_t ray_direction(sample_t s);
		longint du, dv, rf, uf, q28, r;
		longint d[3];
		longint unsigned sum, norm;
		logic signed [15:0] o[3];
		dir_t res;
		du = longint'(s.u) - 32768;
		dv = 32768 - longint'(s.v);
		rf = atan_poly(round_shift(longint'(cam_hfov) * du, 16)) + longint'(s.ju);
		uf = atan_poly(round_shift(longint'(cam_vfov) * dv, 16)) + longint'(s.jv);
		sum = 0;
		for (int k = 0; k < 3; k++) begin
			q28 = comp16(cam_fwd, k) * 16384 + comp16(cam_right, k) * rf
				+ comp16(cam_up, k) * uf;
			d[k] = round_shift(q28, 4);
			sum += longint'(d[k] * d[k]);
		end
		norm = floor_sqrt(sum);
		for (int k = 0; k < 3; k++) begin
			r = 0;
			if (norm != 0) begin
				r = round_div(d[k] * 16384, longint'(norm));
				if (r > 16384) r = 16384;
				if (r < -16384) r = -16384;
			end
			o[k] = r[15:0];
		end
		res.x = o[0];
		res.y = o[1];
		res.z = o[2];
		return res;
	endfunction

	// Driver: start stays high until the transaction is taken.
	always @(posedge clk) begin
		logic    taken, next_start;
		sample_t s;
		taken = start && !busy;
		next_start = start && !taken;
		if (taken)
			expected_dirs.push_back(ray_direction(cur_sample));
		if (!next_start && arst_n) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_samples.size() > 0) begin
				s = pending_samples.pop_front();
				cur_sample <= s;
				screen_u <= s.u;
				screen_v <= s.v;
				jitter_u <= s.ju;
				jitter_v <= s.jv;
				next_start = 1'b1;
				if (burst_left > 0) begin
					burst_left--;
					gap_left = 0;
				end else if ($urandom_range(0, 15) == 0) begin
					burst_left = $urandom_range(10, 40);
					gap_left = 0;
				end else begin
					gap_left = $urandom_range(0, 12);
				end
			end
		end
		start <= next_start;
	end

	// Monitor: results cannot be held off, so each done cycle is checked.
	always @(posedge clk) begin
		dir_t e;
		if (done) begin
			if (expected_dirs.size() == 0) begin
				$error("unexpected result x=%0d y=%0d z=%0d", dir_x, dir_y, dir_z);
				mismatches++;
			end else begin
				e = expected_dirs.pop_front();
				if (dir_x !== e.x) begin
					$error("dir_x expected %0d actual %0d", e.x, dir_x);
					mismatches++;
				end
				if (dir_y !== e.y) begin
					$error("dir_y expected %0d actual %0d", e.y, dir_y);
					mismatches++;
				end
				if (dir_z !== e.z) begin
					$error("dir_z expected %0d actual %0d", e.z, dir_z);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [47:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			prd_pkg::REG_FORWARD: cam_fwd = val;
			prd_pkg::REG_RIGHT:   cam_right = val;
			prd_pkg::REG_UP:      cam_up = val;
			prd_pkg::REG_HFOV:    cam_hfov = val[15:0];
			prd_pkg::REG_VFOV:    cam_vfov = val[15:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_samples.size() > 0 || start || expected_dirs.size() > 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 6) @(posedge clk);
	endtask

	function automatic sample_t make_sample(logic [15:0] u, logic [15:0] v,
		logic [15:0] ju, logic [15:0] jv);
		sample_t s;
		s.u = u;
		s.v = v;
		s.ju = ju;
		s.jv = jv;
		return s;
	endfunction

	function automatic logic [47:0] rand_axis();
		logic [15:0] c[3];
		int sel;
		sel = $urandom_range(0, 3);
		for (int k = 0; k < 3; k++)
			c[k] = (sel == 3) ? 16'($urandom) : (16'($urandom_range(0, 2000)) - 16'd1000);
		if (sel < 3)
			c[sel] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
		return {c[2], c[1], c[0]};
	endfunction

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++)
			pending_samples.push_back(make_sample(16'($urandom), 16'($urandom),
				$urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1024)) - 16'd512,
				$urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1024)) - 16'd512));
	endtask

	initial begin
		logic [15:0] fovs[4];
		cam_fwd = prd_pkg::FORWARD_RST;
		cam_right = prd_pkg::RIGHT_RST;
		cam_up = prd_pkg::UP_RST;
		cam_hfov = prd_pkg::FOV_RST;
		cam_vfov = prd_pkg::FOV_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Corners, centre and jitter extremes under the default camera.
		pending_samples.push_back(make_sample(16'd0, 16'd0, 16'd0, 16'd0));
		pending_samples.push_back(make_sample(16'hFFFF, 16'hFFFF, 16'd0, 16'd0));
		pending_samples.push_back(make_sample(16'h8000, 16'h8000, 16'd0, 16'd0));
		pending_samples.push_back(make_sample(16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF));
		pending_samples.push_back(make_sample(16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000));
		pending_samples.push_back(make_sample(16'h8000, 16'h8000, 16'hFFFF, 16'h0001));
		pending_samples.push_back(make_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
		pending_samples.push_back(make_sample(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
		queue_random(150);
		wait_drained();

		// A zero camera gives a zero-length vector whatever the sample.
		write_reg(prd_pkg::REG_FORWARD, 48'd0);
		write_reg(prd_pkg::REG_RIGHT, 48'd0);
		write_reg(prd_pkg::REG_UP, 48'd0);
		pending_samples.push_back(make_sample(16'h8000, 16'h8000, 16'h7FFF, 16'h8000));
		pending_samples.push_back(make_sample(16'h0000, 16'hFFFF, 16'h0000, 16'h0000));
		wait_drained();

		// Forward and right opposed along x, with the jitter cancelling them out along the axes.
		write_reg(prd_pkg::REG_FORWARD, {16'd0, 16'd0, 16'sd16384});
		write_reg(prd_pkg::REG_RIGHT, {16'd0, 16'd0, -16'sd16384});
		write_reg(prd_pkg::REG_UP, 48'hFFFF_FFFF_FFFF);
		pending_samples.push_back(make_sample(16'h8000, 16'h8000, 16'sd16384, 16'd0));
		pending_samples.push_back(make_sample(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF));
		wait_drained();

		fovs = '{16'd0, FOV_MAX, 16'hFFFF, prd_pkg::FOV_RST};
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(prd_pkg::REG_FORWARD, rand_axis());
			write_reg(prd_pkg::REG_RIGHT, rand_axis());
			write_reg(prd_pkg::REG_UP, rand_axis());
			write_reg(prd_pkg::REG_HFOV,
				ph < 4 ? {32'd0, fovs[ph]} : 48'($urandom_range(0, 65535)));
			write_reg(prd_pkg::REG_VFOV,
				ph < 4 ? {32'd0, fovs[3 - ph]} : 48'($urandom_range(0, 51472)));
			// Indexes past the last register must be ignored.
			write_reg(3'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)), {$urandom, 16'($urandom)});
			queue_random(140);
			wait_drained();
		end

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
